FILE: hw/rtl/cvmidi_pkg.sv
// Shared types and constants for the CV to MIDI controller sender.
// No dependencies; used by every module of the block.
package cvmidi_pkg;

    typedef enum logic [2:0] {
        MODE_OFF     = 3'd0,
        MODE_CC7     = 3'd1,
        MODE_AT      = 3'd2,
        MODE_NRPN7   = 3'd3,
        MODE_PROGRAM = 3'd4,
        MODE_CC14    = 3'd5,
        MODE_BEND    = 3'd6,
        MODE_NRPN14  = 3'd7
    } mode_t;

    typedef enum logic [2:0] {
        REG_MODE      = 3'd0,
        REG_CHANNEL   = 3'd1,
        REG_PARAM_LO  = 3'd2,
        REG_PARAM_HI  = 3'd3,
        REG_RANGE_MIN = 3'd4,
        REG_RANGE_MAX = 3'd5
    } cfg_reg_t;

    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 7;
    localparam int unsigned CV_W       = 14;
    localparam int unsigned VAL_W      = 14;

    typedef struct packed {
        mode_t      mode;
        logic [3:0] channel;
        logic [6:0] param_number;
        logic [6:0] param_high;
        logic [6:0] range_min;
        logic [6:0] range_max;
    } cfg_t;

    // one accepted request that must go out as a run of messages
    typedef struct packed {
        mode_t              mode;
        logic [VAL_W-1:0]   value;
    } job_t;

    // scale factors: 5 V and 3 V in counts, full scales
    localparam logic signed [14:0] BEND_OFFSET = 15'sd4608;  // 3 V
    localparam logic signed [14:0] FULL7       = 15'sd127;
    localparam logic signed [14:0] FULL14      = 15'sd16383;

    // 7680 = 15 << 9, 9216 = 9 << 10; quotient by reciprocal with one correction
    localparam int unsigned RECIP_SHIFT = 24;
    localparam logic [20:0] RECIP15     = 21'd1118481;   // floor(2^24 / 15)
    localparam logic [20:0] RECIP9      = 21'd1864135;   // floor(2^24 / 9)
    localparam logic [3:0]  DIV15       = 4'd15;
    localparam logic [3:0]  DIV9        = 4'd9;

    localparam logic [7:0] ST_CC   = 8'hB0;
    localparam logic [7:0] ST_AT   = 8'hD0;
    localparam logic [7:0] ST_PC   = 8'hC0;
    localparam logic [7:0] ST_BEND = 8'hE0;

    localparam logic [6:0] CC_NRPN_MSB = 7'd99;
    localparam logic [6:0] CC_NRPN_LSB = 7'd98;
    localparam logic [6:0] CC_DATA_MSB = 7'd6;
    localparam logic [6:0] CC_DATA_LSB = 7'd38;
    localparam logic [6:0] CC_LSB_OFS  = 7'd32;

endpackage

FILE: hw/rtl/cvmidi_front.sv
// Front end: scales each CV sample, clamps it and decides whether a run is sent.
// Depends on cvmidi_pkg.
module cvmidi_front
(
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  cvmidi_pkg::cfg_t                        cfg,
    input  logic                                    in_push,
    input  logic signed [cvmidi_pkg::CV_W-1:0]      in_cv,
    output logic                                    in_full,
    output logic                                    jq_push,
    output cvmidi_pkg::job_t                        jq_job,
    input  logic                                    jq_full
);
    import cvmidi_pkg::*;

    logic               seven;
    logic               bend;
    logic               advance;
    logic               accept;

    logic signed [29:0] op_ext;
    logic signed [29:0] k_ext;
    logic signed [14:0] op;

    logic               s1_v_reg, s2_v_reg, s3_v_reg, s4_v_reg, s5_v_reg;
    logic signed [29:0] s1_prod_reg;
    logic [18:0]        s2_x_reg;
    logic               s2_neg_reg;
    logic [15:0]        s3_q0_reg;
    logic [18:0]        s3_x_reg;
    logic               s3_neg_reg;
    logic signed [15:0] s4_val_reg;
    logic signed [15:0] s5_val_reg;

    logic [29:0]        mag;
    logic [18:0]        x;
    logic [39:0]        t;
    logic [19:0]        qd;
    logic [19:0]        r;
    logic [3:0]         d;
    logic [15:0]        q;
    logic signed [15:0] lo;
    logic signed [15:0] hi;
    logic signed [15:0] clamped;
    logic [VAL_W-1:0]   u;
    logic               send;
    logic [15:0]        prev_reg;
    logic [15:0]        prev_next;

    assign seven = (cfg.mode == MODE_CC7) || (cfg.mode == MODE_AT)
                || (cfg.mode == MODE_NRPN7) || (cfg.mode == MODE_PROGRAM);
    assign bend  = (cfg.mode == MODE_BEND);

    // stage 1: signed product
    assign op     = bend ? ({in_cv[CV_W-1], in_cv} + BEND_OFFSET) : {in_cv[CV_W-1], in_cv};
    assign op_ext = {{15{op[14]}}, op};
    assign k_ext  = seven ? {15'sd0, FULL7} : {15'sd0, FULL14};

    // stage 2: magnitude, drop the power-of-two part of the divisor
    assign mag = s1_prod_reg[29] ? (~s1_prod_reg + 30'd1) : s1_prod_reg;
    assign x   = bend ? mag[28:10] : mag[27:9];

    // stage 3: reciprocal multiply
    assign t = {21'd0, s2_x_reg} * {19'd0, (bend ? RECIP9 : RECIP15)};

    // stage 4: correction and sign
    assign d  = bend ? DIV9 : DIV15;
    assign qd = {4'd0, s3_q0_reg} * {16'd0, d};
    assign r  = {1'b0, s3_x_reg} - qd;
    assign q  = s3_q0_reg + {15'd0, (r >= {16'd0, d})};

    // stage 5: clamp, low bound first
    always_comb
    begin
        if (bend)
        begin
            lo = 16'sd0;
            hi = 16'sd16383;
        end
        else if (seven)
        begin
            lo = signed'({9'd0, cfg.range_min});
            hi = signed'({9'd0, cfg.range_max});
        end
        else
        begin
            lo = signed'({2'd0, cfg.range_min, 7'd0});
            hi = signed'({2'd0, cfg.range_max, 7'h7f});
        end
        if (s5_val_reg < lo)
            clamped = lo;
        else if (s5_val_reg > hi)
            clamped = hi;
        else
            clamped = s5_val_reg;
    end

    assign u    = clamped[VAL_W-1:0];
    assign send = s5_v_reg && (cfg.mode != MODE_OFF) && ({2'd0, u} != prev_reg);

    assign advance = !(send && jq_full);
    assign in_full = !advance;
    assign accept  = in_push && advance;

    assign jq_push      = send && !jq_full;
    assign jq_job.mode  = cfg.mode;
    assign jq_job.value = u;

    assign prev_next = jq_push ? {2'd0, u} : prev_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v_reg <= 1'b0;
            s2_v_reg <= 1'b0;
            s3_v_reg <= 1'b0;
            s4_v_reg <= 1'b0;
            s5_v_reg <= 1'b0;
            prev_reg <= 16'hFFFF;
        end
        else
        begin
            prev_reg <= prev_next;
            if (advance)
            begin
                s1_v_reg <= accept;
                s2_v_reg <= s1_v_reg;
                s3_v_reg <= s2_v_reg;
                s4_v_reg <= s3_v_reg;
                s5_v_reg <= s4_v_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s1_prod_reg <= op_ext * k_ext;
            s2_x_reg    <= x;
            s2_neg_reg  <= s1_prod_reg[29];
            s3_q0_reg   <= t[39:RECIP_SHIFT];
            s3_x_reg    <= s2_x_reg;
            s3_neg_reg  <= s2_neg_reg;
            s4_val_reg  <= s3_neg_reg ? signed'(~q + 16'd1) : signed'(q);
            s5_val_reg  <= s4_val_reg;
        end
    end

endmodule

FILE: hw/rtl/cvmidi_jobq.sv
// Small queue of pending runs between front end and message sequencer.
// Depends on cvmidi_pkg.
module cvmidi_jobq
#(
    parameter int unsigned DEPTH = 4
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  cvmidi_pkg::job_t    push_job,
    output logic                full,
    input  logic                pop,
    output cvmidi_pkg::job_t    head,
    output logic                empty
);
    import cvmidi_pkg::*;

    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);

    job_t           mem [DEPTH];
    logic [AW-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]  count_reg, count_next;
    logic           do_push;
    logic           do_pop;

    assign full    = (count_reg == CW'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign head    = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + AW'(1);
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + AW'(1);
        if (do_push && !do_pop)
            count_next = count_reg + CW'(1);
        else if (do_pop && !do_push)
            count_next = count_reg - CW'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem[wr_ptr_reg] <= push_job;
    end

endmodule

FILE: hw/rtl/cvmidi_back.sv
// Back end: expands each queued run into MIDI messages, one per cycle unless the output stalls.
// Depends on cvmidi_pkg.
module cvmidi_back
(
    input  logic                clk,
    input  logic                rst_n,
    input  cvmidi_pkg::cfg_t    cfg,
    input  cvmidi_pkg::job_t    job,
    input  logic                job_empty,
    output logic                job_pop,
    output logic                out_empty,
    input  logic                out_pop,
    output logic [7:0]          out_status,
    output logic [6:0]          out_first,
    output logic [6:0]          out_second,
    output logic                out_last
);
    import cvmidi_pkg::*;

    logic [1:0] idx_reg, idx_next;
    logic       valid_reg, valid_next;
    logic [7:0] status_reg;
    logic [6:0] first_reg;
    logic [6:0] second_reg;
    logic       last_reg;

    logic       load;
    logic [1:0] last_idx;
    logic [7:0] kind;
    logic [6:0] d1;
    logic [6:0] d2;
    logic       is_last;
    logic [6:0] v_hi;
    logic [6:0] v_lo;

    assign v_hi = job.value[13:7];
    assign v_lo = job.value[6:0];

    always_comb
    begin
        kind     = ST_CC;
        d1       = '0;
        d2       = '0;
        last_idx = 2'd0;
        unique case (job.mode)
            MODE_OFF:
            begin
                d1 = '0;
            end
            MODE_CC7:
            begin
                d1 = cfg.param_number;
                d2 = v_lo;
            end
            MODE_AT:
            begin
                kind = ST_AT;
                d1   = v_lo;
            end
            MODE_PROGRAM:
            begin
                kind = ST_PC;
                d1   = v_lo;
            end
            MODE_BEND:
            begin
                kind = ST_BEND;
                d1   = v_lo;
                d2   = v_hi;
            end
            MODE_CC14:
            begin
                last_idx = 2'd1;
                if (idx_reg == 2'd0)
                begin
                    d1 = cfg.param_number;
                    d2 = v_hi;
                end
                else
                begin
                    d1 = cfg.param_number + CC_LSB_OFS;
                    d2 = v_lo;
                end
            end
            MODE_NRPN7, MODE_NRPN14:
            begin
                last_idx = (job.mode == MODE_NRPN7) ? 2'd2 : 2'd3;
                unique case (idx_reg)
                    2'd0:
                    begin
                        d1 = CC_NRPN_MSB;
                        d2 = cfg.param_high;
                    end
                    2'd1:
                    begin
                        d1 = CC_NRPN_LSB;
                        d2 = cfg.param_number;
                    end
                    2'd2:
                    begin
                        d1 = CC_DATA_MSB;
                        d2 = (job.mode == MODE_NRPN7) ? v_lo : v_hi;
                    end
                    default:
                    begin
                        d1 = CC_DATA_LSB;
                        d2 = v_lo;
                    end
                endcase
            end
            default:
            begin
                d1 = '0;
            end
        endcase
    end

    assign is_last = (idx_reg == last_idx);
    assign load    = !job_empty && (!valid_reg || out_pop);
    assign job_pop = load && is_last;

    always_comb
    begin
        idx_next   = idx_reg;
        valid_next = valid_reg;
        if (load)
        begin
            idx_next   = is_last ? 2'd0 : idx_reg + 2'd1;
            valid_next = 1'b1;
        end
        else if (out_pop)
            valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg   <= 2'd0;
            valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg   <= idx_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            status_reg <= kind | {4'd0, cfg.channel};
            first_reg  <= d1;
            second_reg <= d2;
            last_reg   <= is_last;
        end
    end

    assign out_empty  = !valid_reg;
    assign out_status = status_reg;
    assign out_first  = first_reg;
    assign out_second = second_reg;
    assign out_last   = last_reg;

endmodule

FILE: hw/rtl/cv_to_midi_controller_sender.sv
// CV to MIDI controller sender, top level: config registers, front end, run queue, sequencer.
// Depends on cvmidi_pkg, cvmidi_front, cvmidi_jobq, cvmidi_back.
//
//  channel  | handshake         | payload
//  ---------+-------------------+---------------------------------------------------
//  input    | push / full       | cv_sample
//  result   | empty / pop       | status_byte, data_first, data_second, last_of_run
//  config   | cfg_write         | cfg_index, cfg_data
//
// A sample is taken every cycle while full is low; it reaches the run queue after five
// pipeline stages (multiply, magnitude, reciprocal multiply, correction, clamp/compare).
// The sequencer sends one message per cycle while the result side is popped, so a sample
// yields 0 to 4 messages (4 for 14-bit NRPN); the run queue absorbs bursts.
// Reset clears all control state; no clearing pass. full rises only when a sample that
// must send finds the run queue full, and stalls the whole front pipeline.
module cv_to_midi_controller_sender
#(
    parameter int unsigned JQ_DEPTH = 4
)
(
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    cfg_write,
    input  logic [cvmidi_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [cvmidi_pkg::CFG_DATA_W-1:0]       cfg_data,
    input  logic                                    push,
    output logic                                    full,
    input  logic signed [cvmidi_pkg::CV_W-1:0]      cv_sample,
    output logic                                    empty,
    input  logic                                    pop,
    output logic [7:0]                              status_byte,
    output logic [6:0]                              data_first,
    output logic [6:0]                              data_second,
    output logic                                    last_of_run
);
    import cvmidi_pkg::*;

    cfg_t cfg_reg;
    job_t jq_in;
    job_t jq_head;
    logic jq_push;
    logic jq_full;
    logic jq_pop;
    logic jq_empty;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.mode         <= MODE_OFF;
            cfg_reg.channel      <= 4'd0;
            cfg_reg.param_number <= 7'd1;
            cfg_reg.param_high   <= 7'd0;
            cfg_reg.range_min    <= 7'd0;
            cfg_reg.range_max    <= 7'd127;
        end
        else if (cfg_write)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_MODE:      cfg_reg.mode         <= mode_t'(cfg_data[2:0]);
                REG_CHANNEL:   cfg_reg.channel      <= cfg_data[3:0];
                REG_PARAM_LO:  cfg_reg.param_number <= cfg_data;
                REG_PARAM_HI:  cfg_reg.param_high   <= cfg_data;
                REG_RANGE_MIN: cfg_reg.range_min    <= cfg_data;
                REG_RANGE_MAX: cfg_reg.range_max    <= cfg_data;
                default:       cfg_reg.mode         <= cfg_reg.mode;
            endcase
        end
    end

    cvmidi_front u_front
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg_reg),
        .in_push (push),
        .in_cv   (cv_sample),
        .in_full (full),
        .jq_push (jq_push),
        .jq_job  (jq_in),
        .jq_full (jq_full)
    );

    cvmidi_jobq #(.DEPTH(JQ_DEPTH)) u_jobq
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (jq_push),
        .push_job (jq_in),
        .full     (jq_full),
        .pop      (jq_pop),
        .head     (jq_head),
        .empty    (jq_empty)
    );

    cvmidi_back u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .job        (jq_head),
        .job_empty  (jq_empty),
        .job_pop    (jq_pop),
        .out_empty  (empty),
        .out_pop    (pop),
        .out_status (status_byte),
        .out_first  (data_first),
        .out_second (data_second),
        .out_last   (last_of_run)
    );

    a_jq_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        jq_push |-> !jq_full)
        else $error("run queue written while full");

    a_jq_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        jq_pop |-> !jq_empty)
        else $error("run queue read while empty");

    a_off_no_run: assert property (@(posedge clk) disable iff (!rst_n)
        (cfg_reg.mode == MODE_OFF) |-> !jq_push)
        else $error("run queued with mode off");

    a_full_only_on_backlog: assert property (@(posedge clk) disable iff (!rst_n)
        full |-> jq_full)
        else $error("input stalled without a full run queue");

endmodule
